[hw/rtl/lsn_pkg.sv]
// ----------------------------------------------------------------------------
// lsn_pkg
// shared types and constants of the leaky integrate-and-fire network step
// ----------------------------------------------------------------------------
package lsn_pkg;

    localparam int POT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int SPIKE_W = 9;
    localparam int TOTAL_W = 32;
    localparam int TURN_W  = 2;
    localparam int MUL_W   = 16;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [POT_W-1:0] POT_MAX = 16'hFFFF;

    localparam logic [REG_IDX_W-1:0] REG_DECAY     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_POT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_IN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_OUT = 3'd4;

    localparam logic [CFG_W-1:0] DECAY_RST      = 16'd58643;
    localparam logic [CFG_W-1:0] THRESHOLD_RST  = 16'd4096;
    localparam logic [CFG_W-1:0] RESET_POT_RST  = 16'd0;
    localparam logic [CFG_W-1:0] WEIGHT_IN_RST  = 16'd410;
    localparam logic [CFG_W-1:0] WEIGHT_OUT_RST = 16'd410;

    localparam logic signed [TURN_W-1:0] TURN_LEFT     = 2'sd1;
    localparam logic signed [TURN_W-1:0] TURN_RIGHT    = -2'sd1;
    localparam logic signed [TURN_W-1:0] TURN_STRAIGHT = 2'sd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE_IN,
        ST_HID,
        ST_HID_DRAIN,
        ST_SCALE_OUT,
        ST_OUT,
        ST_OUT_DRAIN,
        ST_DONE
    } lsn_state_t;

    typedef struct packed {
        logic s_ready;
        logic issue;
        logic rd_en;
        logic scale_in;
        logic scale_out;
        logic deliver;
    } lsn_ctrl_t;

endpackage

[hw/rtl/lsn_ram.sv]
// ----------------------------------------------------------------------------
// lsn_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module lsn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/lif_spiking_net_step.sv]
// ----------------------------------------------------------------------------
// lif_spiking_net_step
// one time step of a two layer leaky integrate-and-fire spiking network
// ----------------------------------------------------------------------------
// each item on the s_ channel is one time step with the input spike bits.
// the block leaks and integrates every hidden neuron, then both output
// neurons, and returns one item on the m_ channel with the two output
// spikes, the turn command and the saturating output spike total.
// all neurons share one 16x16 multiplier; hidden potentials live in a
// ram with one read and one write port, read one neuron per cycle.
// from accept to result, an item passes through input weight scaling, one
// read per hidden neuron on the ram read port, pipeline drain, output
// weight scaling, the two output neurons and a final drain. s_ready is
// high only while no step is in progress; a finished result sits in the
// output register, and the next item is accepted while it waits. if the
// receiver stalls, a later step holds at its end until the output
// register is free. reset loads default configuration, clears hidden
// potentials through per-neuron valid bits, clears output potentials and
// the spike total. the user must write configuration over the apb port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lif_spiking_net_step #(
    parameter int NUM_INPUTS = 9,
    parameter int NUM_HIDDEN = 20
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lsn_pkg::SPIKE_W-1:0]          s_input_spikes,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_left_spike,
    output logic                                 m_right_spike,
    output logic signed [lsn_pkg::TURN_W-1:0]    m_turn_command,
    output logic [lsn_pkg::TOTAL_W-1:0]          m_spike_total,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsn_pkg::PADDR_W-1:0]          paddr,
    input  logic [lsn_pkg::PDATA_W-1:0]          pwdata,
    output logic [lsn_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam int IN_USED = (NUM_INPUTS < lsn_pkg::SPIKE_W) ? NUM_INPUTS : lsn_pkg::SPIKE_W;
    localparam int CNT_MAX = (NUM_HIDDEN > lsn_pkg::SPIKE_W) ? NUM_HIDDEN : lsn_pkg::SPIKE_W;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int INC_W   = CNT_W + lsn_pkg::CFG_W;
    localparam int SUM_W   = INC_W + 1;
    localparam int IDX_W   = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
    localparam int PROD_W  = 2 * lsn_pkg::MUL_W;

    // configuration
    logic [lsn_pkg::CFG_W-1:0] decay_reg, thr_reg, rst_pot_reg, w_in_reg, w_out_reg;
    logic                      cfg_we;
    logic [lsn_pkg::REG_IDX_W-1:0] cfg_idx;

    // sequencer
    lsn_pkg::lsn_state_t state_reg, state_next;
    lsn_pkg::lsn_ctrl_t  ctrl;
    logic [IDX_W-1:0]    idx_reg;
    logic                idx_last;
    logic                out_phase_reg;

    // datapath
    logic [lsn_pkg::SPIKE_W-1:0] spikes_reg;
    logic [CNT_W-1:0]            in_cnt;
    logic [CNT_W-1:0]            hid_cnt_reg;
    logic [INC_W-1:0]            inc_reg;
    logic [NUM_HIDDEN-1:0]       valid_reg;
    logic [lsn_pkg::POT_W-1:0]   out_pot_reg [2];
    logic [1:0]                  fired_reg;
    logic [lsn_pkg::TOTAL_W-1:0] spike_cnt_reg;

    logic                        p1_reg, p1_vbit_reg, p2_reg;
    logic [IDX_W-1:0]            p1_addr_reg, p2_addr_reg;
    logic [lsn_pkg::POT_W-1:0]   opnd_reg;
    logic [PROD_W-1:0]           prod_reg;

    logic [lsn_pkg::POT_W-1:0]   rd_data, p1_opnd;
    logic [lsn_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]           mul_p;
    logic [SUM_W-1:0]            sum;
    logic [lsn_pkg::POT_W-1:0]   sat, new_pot;
    logic                        fire;
    logic                        ram_we;

    logic [lsn_pkg::TOTAL_W:0]   cnt_sum;
    logic [lsn_pkg::TOTAL_W-1:0] cnt_next;

    logic                        m_valid_reg, m_left_reg, m_right_reg;
    logic signed [lsn_pkg::TURN_W-1:0] m_turn_reg;
    logic [lsn_pkg::TOTAL_W-1:0] m_total_reg;

    // apb port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[lsn_pkg::PADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg   <= lsn_pkg::DECAY_RST;
            thr_reg     <= lsn_pkg::THRESHOLD_RST;
            rst_pot_reg <= lsn_pkg::RESET_POT_RST;
            w_in_reg    <= lsn_pkg::WEIGHT_IN_RST;
            w_out_reg   <= lsn_pkg::WEIGHT_OUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                lsn_pkg::REG_DECAY:      decay_reg   <= pwdata[lsn_pkg::CFG_W-1:0];
                lsn_pkg::REG_THRESHOLD:  thr_reg     <= pwdata[lsn_pkg::CFG_W-1:0];
                lsn_pkg::REG_RESET_POT:  rst_pot_reg <= pwdata[lsn_pkg::CFG_W-1:0];
                lsn_pkg::REG_WEIGHT_IN:  w_in_reg    <= pwdata[lsn_pkg::CFG_W-1:0];
                lsn_pkg::REG_WEIGHT_OUT: w_out_reg   <= pwdata[lsn_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            lsn_pkg::REG_DECAY:      prdata = lsn_pkg::PDATA_W'(decay_reg);
            lsn_pkg::REG_THRESHOLD:  prdata = lsn_pkg::PDATA_W'(thr_reg);
            lsn_pkg::REG_RESET_POT:  prdata = lsn_pkg::PDATA_W'(rst_pot_reg);
            lsn_pkg::REG_WEIGHT_IN:  prdata = lsn_pkg::PDATA_W'(w_in_reg);
            lsn_pkg::REG_WEIGHT_OUT: prdata = lsn_pkg::PDATA_W'(w_out_reg);
            default:                 prdata = '0;
        endcase
    end

    // input spike count
    always_comb begin
        in_cnt = '0;
        for (int i = 0; i < IN_USED; i++) begin
            in_cnt = in_cnt + CNT_W'(spikes_reg[i]);
        end
    end

    assign idx_last = (idx_reg == IDX_W'(NUM_HIDDEN - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsn_pkg::ST_IDLE:      if (s_valid) state_next = lsn_pkg::ST_SCALE_IN;
            lsn_pkg::ST_SCALE_IN:  state_next = lsn_pkg::ST_HID;
            lsn_pkg::ST_HID:       if (idx_last) state_next = lsn_pkg::ST_HID_DRAIN;
            lsn_pkg::ST_HID_DRAIN: if (!p1_reg && !p2_reg) state_next = lsn_pkg::ST_SCALE_OUT;
            lsn_pkg::ST_SCALE_OUT: state_next = lsn_pkg::ST_OUT;
            lsn_pkg::ST_OUT:       if (idx_reg[0]) state_next = lsn_pkg::ST_OUT_DRAIN;
            lsn_pkg::ST_OUT_DRAIN: if (!p1_reg && !p2_reg) state_next = lsn_pkg::ST_DONE;
            lsn_pkg::ST_DONE:      if (!m_valid_reg || m_ready) state_next = lsn_pkg::ST_IDLE;
            default:               state_next = lsn_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            lsn_pkg::ST_IDLE:      ctrl.s_ready   = 1'b1;
            lsn_pkg::ST_SCALE_IN:  ctrl.scale_in  = 1'b1;
            lsn_pkg::ST_HID: begin
                ctrl.issue = 1'b1;
                ctrl.rd_en = 1'b1;
            end
            lsn_pkg::ST_SCALE_OUT: ctrl.scale_out = 1'b1;
            lsn_pkg::ST_OUT:       ctrl.issue     = 1'b1;
            lsn_pkg::ST_DONE:      ctrl.deliver   = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign s_ready = ctrl.s_ready;

    // shared multiplier
    assign p1_opnd = out_phase_reg ? opnd_reg : (p1_vbit_reg ? rd_data : '0);

    always_comb begin
        if (ctrl.scale_in) begin
            mul_a = lsn_pkg::MUL_W'(in_cnt);
            mul_b = w_in_reg;
        end else if (ctrl.scale_out) begin
            mul_a = lsn_pkg::MUL_W'(hid_cnt_reg);
            mul_b = w_out_reg;
        end else begin
            mul_a = p1_opnd;
            mul_b = decay_reg;
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // integrate, saturate, fire
    assign sum     = SUM_W'(prod_reg[PROD_W-1:lsn_pkg::MUL_W]) + SUM_W'(inc_reg);
    assign sat     = (sum > SUM_W'(lsn_pkg::POT_MAX)) ? lsn_pkg::POT_MAX
                                                      : sum[lsn_pkg::POT_W-1:0];
    assign fire    = (sat >= thr_reg);
    assign new_pot = fire ? rst_pot_reg : sat;
    assign ram_we  = p2_reg && !out_phase_reg;

    lsn_ram #(
        .WIDTH (lsn_pkg::POT_W),
        .DEPTH (NUM_HIDDEN)
    ) u_hid_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (p2_addr_reg),
        .wdata (new_pot),
        .re    (ctrl.rd_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // spike total
    assign cnt_sum  = {1'b0, spike_cnt_reg} + (lsn_pkg::TOTAL_W + 1)'(fired_reg[0])
                    + (lsn_pkg::TOTAL_W + 1)'(fired_reg[1]);
    assign cnt_next = cnt_sum[lsn_pkg::TOTAL_W] ? '1 : cnt_sum[lsn_pkg::TOTAL_W-1:0];

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lsn_pkg::ST_IDLE;
            idx_reg       <= '0;
            out_phase_reg <= 1'b0;
            hid_cnt_reg   <= '0;
            valid_reg     <= '0;
            out_pot_reg[0] <= '0;
            out_pot_reg[1] <= '0;
            fired_reg     <= '0;
            spike_cnt_reg <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            p1_reg    <= ctrl.issue;
            p2_reg    <= p1_reg;

            if (ctrl.scale_in) begin
                idx_reg       <= '0;
                out_phase_reg <= 1'b0;
                hid_cnt_reg   <= '0;
                fired_reg     <= '0;
            end else if (ctrl.scale_out) begin
                idx_reg       <= '0;
                out_phase_reg <= 1'b1;
            end else if (ctrl.issue) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (p2_reg) begin
                if (out_phase_reg) begin
                    out_pot_reg[p2_addr_reg[0]] <= new_pot;
                    fired_reg[p2_addr_reg[0]]   <= fire;
                end else begin
                    valid_reg[p2_addr_reg] <= 1'b1;
                    if (fire) begin
                        hid_cnt_reg <= hid_cnt_reg + CNT_W'(1);
                    end
                end
            end

            if (ctrl.deliver) begin
                spike_cnt_reg <= cnt_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && ctrl.s_ready) begin
            spikes_reg <= s_input_spikes;
        end
        if (ctrl.scale_in || ctrl.scale_out) begin
            inc_reg <= mul_p[INC_W-1:0];
        end
        if (ctrl.issue) begin
            p1_addr_reg <= idx_reg;
            p1_vbit_reg <= valid_reg[idx_reg];
            opnd_reg    <= out_pot_reg[idx_reg[0]];
        end
        if (p1_reg) begin
            prod_reg    <= mul_p;
            p2_addr_reg <= p1_addr_reg;
        end
        if (ctrl.deliver) begin
            m_left_reg  <= fired_reg[0];
            m_right_reg <= fired_reg[1];
            m_total_reg <= cnt_next;
            if (fired_reg[0] && !fired_reg[1]) begin
                m_turn_reg <= lsn_pkg::TURN_LEFT;
            end else if (fired_reg[1] && !fired_reg[0]) begin
                m_turn_reg <= lsn_pkg::TURN_RIGHT;
            end else begin
                m_turn_reg <= lsn_pkg::TURN_STRAIGHT;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_spike   = m_left_reg;
    assign m_right_spike  = m_right_reg;
    assign m_turn_command = m_turn_reg;
    assign m_spike_total  = m_total_reg;

`ifndef SYNTHESIS
    a_hid_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hid_cnt_reg <= CNT_W'(NUM_HIDDEN))
        else $error("hidden fire count beyond neuron count");

    a_no_rw_hazard: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ctrl.rd_en) |-> (p2_addr_reg != idx_reg))
        else $error("ram read and write at the same neuron");

    a_scale_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.scale_in || ctrl.scale_out) |-> (!p1_reg && !p2_reg))
        else $error("multiplier shared while pipeline busy");

    a_turn_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_left_spike == m_right_spike)
                     == (m_turn_command == lsn_pkg::TURN_STRAIGHT)))
        else $error("turn command does not match output spikes");

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.deliver |=> (spike_cnt_reg >= $past(spike_cnt_reg)))
        else $error("spike total decreased");
`endif

endmodule
